>>> sv/wssm_pkg.sv
`timescale 1ns / 1ps
// wssm_pkg: shared constants, register map and state type for the working set size monitor.
// No dependencies.
package wssm_pkg;

  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned WSIZE_W  = 25;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned WIN_W    = 32;
  localparam int unsigned EPOCH_W  = 8;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(13);
  localparam logic [WSIZE_W-1:0] WSIZE_RST = WSIZE_W'(1024);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};

  typedef enum logic {
    REG_PAGE_SHIFT  = 1'b0,
    REG_WINDOW_SIZE = 1'b1
  } wssm_reg_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } wssm_state_e;

endpackage

>>> sv/working_set_size_monitor.sv
`timescale 1ns / 1ps
// working_set_size_monitor: top level with register file, front, queue and back.
// Depends on wssm_pkg, wssm_front, wssm_queue, wssm_back.
//
//   channel | signals                               | transfer when
//   in      | address_i                             | in_valid_i & !in_stall_o
//   out     | window_number_o, working_set_size_o   | out_valid_o & !out_stall_i
//   cfg     | psel, penable, pwrite, paddr, pwdata  | psel & penable & pwrite
//
// One address per cycle when PAGE_ENTRIES is a power of two, unless the queue
// is full or the map is swept; otherwise the page remainder unit takes one
// address at a time and stalls the input until it has pushed that page.
// A result is registered once the address closing its window has left the queue
// and been read from the seen map, read on pop and written when a new page
// is counted, with a one-deep bypass. After reset, and after every 256th window,
// all PAGE_ENTRIES map entries are cleared in turn; no address is taken during
// the sweep. A stalled result holds the back end once the next window completes.
module working_set_size_monitor import wssm_pkg::*; #(
  parameter int unsigned ADDR_BITS    = 25,
  parameter int unsigned PAGE_ENTRIES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ADDR_BITS-1:0] address_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WIN_W-1:0]     window_number_o,
  output logic [COUNT_W-1:0]   working_set_size_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int unsigned PW = $clog2(PAGE_ENTRIES);

  logic [SHIFT_W-1:0] page_shift_q;
  logic [WSIZE_W-1:0] window_size_q;
  wssm_reg_e          reg_sel;
  logic               cfg_wr;

  logic          q_push, q_full, q_pop, q_vld, clearing;
  logic [PW-1:0] q_wpage, q_rpage;

  assign pready  = 1'b1;
  assign reg_sel = wssm_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      REG_PAGE_SHIFT:  prdata = APB_DW'(page_shift_q);
      REG_WINDOW_SIZE: prdata = APB_DW'(window_size_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q  <= SHIFT_RST;
      window_size_q <= WSIZE_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_PAGE_SHIFT:  page_shift_q  <= pwdata[SHIFT_W-1:0];
        REG_WINDOW_SIZE: window_size_q <= pwdata[WSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  wssm_front #(
    .ADDR_BITS    (ADDR_BITS),
    .PAGE_ENTRIES (PAGE_ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .address_i    (address_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .page_shift_i (page_shift_q),
    .clearing_i   (clearing),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_page_o     (q_wpage)
  );

  wssm_queue #(
    .WIDTH (PW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wpage),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_vld),
    .rdata_o (q_rpage)
  );

  wssm_back #(
    .PAGE_ENTRIES (PAGE_ENTRIES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_vld),
    .q_page_i           (q_rpage),
    .q_pop_o            (q_pop),
    .clearing_o         (clearing),
    .window_size_i      (window_size_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .window_number_o    (window_number_o),
    .working_set_size_o (working_set_size_o)
  );

`ifndef SYNTHESIS
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> working_set_size_o != '0)
    else $error("window reported with no pages");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(working_set_size_o) <= 32'(PAGE_ENTRIES))
    else $error("distinct page count exceeds map size");

  a_window_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=>
      !out_valid_o || window_number_o == $past(window_number_o) + 32'd1)
    else $error("window numbers out of sequence");
`endif

endmodule

>>> sv/wssm_ram.sv
`timescale 1ns / 1ps
// wssm_ram: generic single-write, single-read RAM with registered read (old data on collision).
// No dependencies.
module wssm_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/wssm_front.sv
`timescale 1ns / 1ps
// wssm_front: accepts addresses and turns them into page indices for the queue.
// Depends on wssm_pkg.
module wssm_front import wssm_pkg::*; #(
  parameter int unsigned ADDR_BITS    = 25,
  parameter int unsigned PAGE_ENTRIES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ADDR_BITS-1:0]            address_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SHIFT_W-1:0]              page_shift_i,
  input  logic                            clearing_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output logic [$clog2(PAGE_ENTRIES)-1:0] q_page_o
);

  localparam int unsigned PW     = $clog2(PAGE_ENTRIES);
  localparam int unsigned SW     = (ADDR_BITS > PW) ? ADDR_BITS : PW;
  localparam bit          IsPow2 = (PAGE_ENTRIES & (PAGE_ENTRIES - 1)) == 0;

  logic [SW-1:0] shifted;

  assign shifted = SW'(address_i) >> page_shift_i;

  if (IsPow2) begin : g_mask
    assign in_stall_o = q_full_i || clearing_i;
    assign q_push_o   = in_valid_i && !in_stall_o;
    assign q_page_o   = shifted[PW-1:0];
  end else begin : g_recip
    // page = x - N * floor(x * R / 2^(SW+PW)), exact for every SW-bit x
    localparam int unsigned     PRW    = 2 * SW + PW;
    localparam longint unsigned Scale  = 64'(1) << (SW + PW);
    localparam longint unsigned RecipL =
      (Scale + 64'(PAGE_ENTRIES) - 64'(1)) / 64'(PAGE_ENTRIES);
    localparam logic [SW:0]     Recip  = (SW+1)'(RecipL);
    localparam logic [SW-1:0]   NMod   = SW'(PAGE_ENTRIES);

    logic           busy_q, busy_d;
    logic [1:0]     step_q, step_d;
    logic [SW-1:0]  sh_q, sh_d;
    logic [SW-1:0]  quot_q, quot_d;
    logic [PW-1:0]  rem_q, rem_d;
    logic [PRW-1:0] prod;
    logic [SW-1:0]  fold;
    logic           accept;

    assign in_stall_o = busy_q || clearing_i;
    assign accept     = in_valid_i && !in_stall_o;
    assign prod       = PRW'(sh_q) * PRW'(Recip);
    assign fold       = sh_q - quot_q * NMod;
    assign q_push_o   = busy_q && (step_q == 2'd0) && !q_full_i;
    assign q_page_o   = rem_q;

    always_comb begin
      busy_d = busy_q;
      step_d = step_q;
      sh_d   = sh_q;
      quot_d = quot_q;
      rem_d  = rem_q;
      if (accept) begin
        busy_d = 1'b1;
        sh_d   = shifted;
        step_d = 2'd2;
      end else if (busy_q && step_q == 2'd2) begin
        quot_d = prod[SW+PW +: SW];
        step_d = 2'd1;
      end else if (busy_q && step_q == 2'd1) begin
        rem_d  = fold[PW-1:0];
        step_d = 2'd0;
      end else if (q_push_o) begin
        busy_d = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        step_q <= 2'd0;
      end else begin
        busy_q <= busy_d;
        step_q <= step_d;
      end
    end

    always_ff @(posedge clk_i) begin
      sh_q   <= sh_d;
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

endmodule

>>> sv/wssm_queue.sv
`timescale 1ns / 1ps
// wssm_queue: two-entry queue of page indices between front and back.
// Depends on wssm_pkg.
module wssm_queue import wssm_pkg::*; #(
  parameter int unsigned WIDTH = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] buf_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = buf_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> sv/wssm_back.sv
`timescale 1ns / 1ps
// wssm_back: seen map with epoch tags, distinct count, window position and result register.
// Depends on wssm_pkg and wssm_ram.
module wssm_back import wssm_pkg::*; #(
  parameter int unsigned PAGE_ENTRIES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  logic [$clog2(PAGE_ENTRIES)-1:0] q_page_i,
  output logic                            q_pop_o,
  output logic                            clearing_o,
  input  logic [WSIZE_W-1:0]              window_size_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [WIN_W-1:0]                window_number_o,
  output logic [COUNT_W-1:0]              working_set_size_o
);

  localparam int unsigned PW = $clog2(PAGE_ENTRIES);
  localparam int unsigned RW = EPOCH_W + 1;

  wssm_state_e state_q, state_d;

  logic [PW-1:0]      clr_cnt_q, clr_cnt_d;
  logic               w_vld_q, w_vld_d;
  logic [PW-1:0]      w_page_q;
  logic               fwd_q;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [WIN_W-1:0]   win_q, win_d;
  logic               out_vld_q, out_vld_d;
  logic [WIN_W-1:0]   out_win_q;
  logic [COUNT_W-1:0] out_cnt_q;

  logic [EPOCH_W-1:0] epoch;
  logic [POS_W-1:0]   last;
  logic [RW-1:0]      rdata, wdata;
  logic [PW-1:0]      waddr;
  logic               we, seen, w_end, w_fire, out_free, wrap;
  logic [COUNT_W-1:0] cnt_new;

  assign epoch = win_q[EPOCH_W-1:0];
  assign wrap  = &epoch;
  assign last  = (window_size_i == '0) ? '0 :
                 window_size_i[WSIZE_W-1] ? POS_MAX :
                 POS_W'(window_size_i - WSIZE_W'(1));

  assign seen     = fwd_q || (rdata[RW-1] && rdata[EPOCH_W-1:0] == epoch);
  assign w_end    = pos_q >= last;
  assign out_free = !out_vld_q || !out_stall_i;
  assign w_fire   = (state_q == ST_RUN) && w_vld_q && (!w_end || out_free);
  assign cnt_new  = (seen || cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    q_pop_o   = 1'b0;
    we        = 1'b0;
    waddr     = w_page_q;
    wdata     = {1'b1, epoch};
    case (state_q)
      ST_CLEAR: begin
        we        = 1'b1;
        waddr     = clr_cnt_q;
        wdata     = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == PW'(PAGE_ENTRIES - 1)) begin
          state_d   = ST_RUN;
          clr_cnt_d = '0;
        end
      end
      ST_RUN: begin
        we      = w_fire && !seen;
        q_pop_o = q_valid_i && (!w_vld_q || w_fire) && !(w_fire && w_end && wrap);
        if (w_fire && w_end && wrap) begin
          state_d = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign clearing_o = state_q == ST_CLEAR;

  wssm_ram #(
    .WIDTH (RW),
    .DEPTH (PAGE_ENTRIES)
  ) u_seen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (q_pop_o),
    .raddr_i (q_page_i),
    .rdata_o (rdata)
  );

  always_comb begin
    w_vld_d   = w_vld_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    win_d     = win_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (q_pop_o) begin
      w_vld_d = 1'b1;
    end else if (w_fire) begin
      w_vld_d = 1'b0;
    end
    if (w_fire) begin
      if (w_end) begin
        out_vld_d = 1'b1;
        cnt_d     = '0;
        pos_d     = '0;
        win_d     = win_q + 1'b1;
      end else begin
        cnt_d = cnt_new;
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      w_vld_q   <= 1'b0;
      fwd_q     <= 1'b0;
      cnt_q     <= '0;
      pos_q     <= '0;
      win_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      w_vld_q   <= w_vld_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      win_q     <= win_d;
      out_vld_q <= out_vld_d;
      if (q_pop_o) begin
        // page written this cycle is read stale; remember the hit
        fwd_q <= w_fire && !w_end && (w_page_q == q_page_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      w_page_q <= q_page_i;
    end
    if (w_fire && w_end) begin
      out_win_q <= win_q;
      out_cnt_q <= cnt_new;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign window_number_o    = out_win_q;
  assign working_set_size_o = out_cnt_q;

endmodule
